// File: rtl/core/gb3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_pkg
// Shared types, constants and the per-channel blur kernel of the 3x3 blur.
// ----------------------------------------------------------------------------
package gb3_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int MAX_HEIGHT    = 4096;
  localparam int CFG_W         = 13;
  localparam int COORD_W       = 12;
  localparam int PIX_W         = 24;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes
  typedef enum logic {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  // {red, green, blue}, blue in the low byte
  typedef logic [PIX_W-1:0] pixel_t;

  // One window column: two stored rows above and the arriving row
  typedef struct packed {
    pixel_t up;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Position flags of one pixel in the frame
  typedef struct packed {
    logic rge1;
    logic rge2;
    logic cge1;
    logic cge2;
    logic col_last;
    logic row_last;
  } edge_t;

  typedef struct packed {
    pixel_t             pix;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } result_t;

  // Up to three results caused by one pixel, packed from slot 0
  typedef struct packed {
    logic              push;
    logic [1:0]        count;
    result_t [2:0]     slot;
  } res_group_t;

  // 1-2-1 x 1-2-1 kernel on each channel, divide by 16 with truncation
  function automatic pixel_t blur_px(column_t a, column_t b, column_t d);
    logic [11:0] s;
    pixel_t      res;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      s = 12'(a.up[ch*8 +: 8])          + (12'(b.up[ch*8 +: 8]) << 1)
        + 12'(d.up[ch*8 +: 8])
        + (12'(a.mid[ch*8 +: 8]) << 1)  + (12'(b.mid[ch*8 +: 8]) << 2)
        + (12'(d.mid[ch*8 +: 8]) << 1)
        + 12'(a.bot[ch*8 +: 8])         + (12'(b.bot[ch*8 +: 8]) << 1)
        + 12'(d.bot[ch*8 +: 8]);
      res[ch*8 +: 8] = s[11:4];
    end
    return res;
  endfunction

endpackage

// File: rtl/core/gaussian_blur_3x3_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb
// Streaming 3x3 Gaussian blur of a raster-order RGB pixel stream.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns each pixel one row and one column
// later, blurred with the 1-2-1 x 1-2-1 kernel (truncated divide by 16) or
// passed through on the frame border, tagged with its row and column. A pixel
// causes zero results in the top row, one in most places, and two or three at
// the last column and in the bottom row; the output register moves one result
// per clock while out_stall is low, so such pixels hold off the input until
// their results drain. The two line stores share one MAX_WIDTH x 48 RAM, read
// on input transfer and written back when the window stage passes the pixel
// on; a pixel whose address matches the write in flight is forwarded. No
// clearing pass runs after reset; image_width and image_height are clamped to
// 3..MAX_WIDTH and 3..4096 and may be written only while the block is idle.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgb #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_write,
  input  logic                        cfg_index,
  input  logic [gb3_pkg::CFG_W-1:0]   cfg_data,
  // pixel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  blue_in,
  input  logic [7:0]                  green_in,
  input  logic [7:0]                  red_in,
  input  logic                        frame_start,
  // result output
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  blue_out,
  output logic [7:0]                  green_out,
  output logic [7:0]                  red_out,
  output logic [gb3_pkg::COORD_W-1:0] out_row,
  output logic [gb3_pkg::COORD_W-1:0] out_col,
  output logic                        last_of_run
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [gb3_pkg::CFG_W-1:0]    image_width;
  logic [gb3_pkg::CFG_W-1:0]    image_height;
  logic                         in_accept;
  logic                         out_accept;
  logic [CW-1:0]                col;
  logic [gb3_pkg::COORD_W-1:0]  row;
  gb3_pkg::edge_t               edges;
  logic [2*gb3_pkg::PIX_W-1:0]  ram_rdata;
  logic                         ram_we;
  logic [CW-1:0]                ram_waddr;
  logic [2*gb3_pkg::PIX_W-1:0]  ram_wdata;
  logic                         busy;
  logic                         emit_ready;
  gb3_pkg::res_group_t          group;
  gb3_pkg::result_t             out_res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= gb3_pkg::WIDTH_RESET;
      image_height <= gb3_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      if (cfg_index == gb3_pkg::REG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end else begin
        image_height <= cfg_data;
      end
    end
  end

  assign in_stall   = busy;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  gb3_raster #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_raster (
    .clk          (clk),
    .rst          (rst),
    .advance      (in_accept),
    .frame_start  (frame_start),
    .image_width  (image_width),
    .image_height (image_height),
    .col          (col),
    .row          (row),
    .edges        (edges)
  );

  // Line stores: upper row in the high half, middle row in the low half
  gb3_ram #(
    .WIDTH (2 * gb3_pkg::PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_accept),
    .raddr (col),
    .rdata (ram_rdata)
  );

  gb3_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .pix_in     ({red_in, green_in, blue_in}),
    .col        (col),
    .row        (row),
    .edges      (edges),
    .ram_rdata  (ram_rdata),
    .emit_ready (emit_ready),
    .busy       (busy),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .group      (group)
  );

  gb3_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .group      (group),
    .out_accept (out_accept),
    .ready      (emit_ready),
    .out_valid  (out_valid),
    .out_res    (out_res)
  );

  assign blue_out    = out_res.pix[7:0];
  assign green_out   = out_res.pix[15:8];
  assign red_out     = out_res.pix[23:16];
  assign out_row     = out_res.row;
  assign out_col     = out_res.col;
  assign last_of_run = out_res.last;

endmodule

// File: rtl/core/gb3_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module gb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read; a read of the address being written returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/gb3_raster.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_raster
// Row and column counters of the raster scan, with size clamping and wrap.
// ----------------------------------------------------------------------------
module gb3_raster #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic                         frame_start,
  input  logic [gb3_pkg::CFG_W-1:0]    image_width,
  input  logic [gb3_pkg::CFG_W-1:0]    image_height,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output logic [gb3_pkg::COORD_W-1:0]  row,
  output gb3_pkg::edge_t               edges
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = CW + 1;

  logic [CW-1:0]                col_count;
  logic [CW-1:0]                col_count_next;
  logic [gb3_pkg::COORD_W-1:0]  row_count;
  logic [gb3_pkg::COORD_W-1:0]  row_count_next;
  logic [WW-1:0]                w_eff;
  logic [gb3_pkg::CFG_W-1:0]    h_eff;
  logic [CW-1:0]                cc0;
  logic [gb3_pkg::COORD_W-1:0]  rc0;
  logic [gb3_pkg::CFG_W-1:0]    row_tmp;
  logic [WW-1:0]                col_inc;
  logic [gb3_pkg::CFG_W-1:0]    row_inc;

  // Clamp the frame size to the supported range
  always_comb begin
    if (image_width < 13'd3) begin
      w_eff = WW'(3);
    end else if ({19'd0, image_width} > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height < 13'd3) begin
      h_eff = 13'd3;
    end else if (image_height > 13'(gb3_pkg::MAX_HEIGHT)) begin
      h_eff = 13'(gb3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  // Position of the arriving pixel, wrapped if the size shrank
  always_comb begin
    cc0 = frame_start ? '0 : col_count;
    rc0 = frame_start ? '0 : row_count;
    if ({1'b0, cc0} >= w_eff) begin
      col     = '0;
      row_tmp = {1'b0, rc0} + 13'd1;
    end else begin
      col     = cc0;
      row_tmp = {1'b0, rc0};
    end
    row = (row_tmp >= h_eff) ? '0 : row_tmp[gb3_pkg::COORD_W-1:0];
  end

  // Advance past the arriving pixel
  always_comb begin
    col_inc = {1'b0, col} + WW'(1);
    row_inc = {1'b0, row} + 13'd1;
    if (col_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (row_inc >= h_eff) ? '0 : row_inc[gb3_pkg::COORD_W-1:0];
    end else begin
      col_count_next = col_inc[CW-1:0];
      row_count_next = row;
    end
  end

  // Flags for the window stage
  always_comb begin
    edges.rge1     = (row != '0);
    edges.rge2     = (row >= 12'd2);
    edges.cge1     = (col != '0);
    edges.cge2     = (col >= CW'(2));
    edges.col_last = ({1'b0, col} == (w_eff - WW'(1)));
    edges.row_last = ({1'b0, row} == (h_eff - 13'd1));
  end

  // Hold counters between transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (advance) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

// File: rtl/core/gb3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_window
// Line-store read-back, 3x3 window, blur and result selection for one pixel.
// ----------------------------------------------------------------------------
module gb3_window #(
  parameter int MAX_WIDTH = gb3_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_accept,
  input  gb3_pkg::pixel_t              pix_in,
  input  logic [$clog2(MAX_WIDTH)-1:0] col,
  input  logic [gb3_pkg::COORD_W-1:0]  row,
  input  gb3_pkg::edge_t               edges,
  input  logic [2*gb3_pkg::PIX_W-1:0]  ram_rdata,
  input  logic                         emit_ready,
  output logic                         busy,
  output logic                         ram_we,
  output logic [$clog2(MAX_WIDTH)-1:0] ram_waddr,
  output logic [2*gb3_pkg::PIX_W-1:0]  ram_wdata,
  output gb3_pkg::res_group_t          group
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic                         s1_valid;
  gb3_pkg::pixel_t              s1_pix;
  logic [CW-1:0]                s1_col;
  logic [gb3_pkg::COORD_W-1:0]  s1_row;
  gb3_pkg::edge_t               s1_edge;
  logic                         s1_fwd;
  logic [2*gb3_pkg::PIX_W-1:0]  s1_fwd_data;
  logic                         s1_go;
  logic [2*gb3_pkg::PIX_W-1:0]  line;
  gb3_pkg::column_t             cur;
  gb3_pkg::column_t             win0;
  gb3_pkg::column_t             win1;
  logic                         emit_diag;
  logic                         emit_right;
  logic                         emit_bottom;
  gb3_pkg::result_t             res_diag;
  gb3_pkg::result_t             res_right;
  gb3_pkg::result_t             res_bottom;
  gb3_pkg::result_t [2:0]       slots;
  logic [1:0]                   count;

  // Current column: stored rows (forwarded on a same-address write) and new pixel
  always_comb begin
    line    = s1_fwd ? s1_fwd_data : ram_rdata;
    cur.up  = line[2*gb3_pkg::PIX_W-1:gb3_pkg::PIX_W];
    cur.mid = line[gb3_pkg::PIX_W-1:0];
    cur.bot = s1_pix;
  end

  // Which results this pixel causes
  assign emit_diag   = s1_edge.rge1 && s1_edge.cge1;
  assign emit_right  = s1_edge.rge1 && s1_edge.col_last;
  assign emit_bottom = s1_edge.rge1 && s1_edge.row_last;

  always_comb begin
    res_diag.pix  = (s1_edge.rge2 && s1_edge.cge2) ?
                    gb3_pkg::blur_px(win0, win1, cur) : win1.mid;
    res_diag.row  = s1_row - 12'd1;
    res_diag.col  = 12'(s1_col - CW'(1));
    res_diag.last = 1'b0;

    res_right.pix  = cur.mid;
    res_right.row  = s1_row - 12'd1;
    res_right.col  = 12'(s1_col);
    res_right.last = 1'b0;

    res_bottom.pix  = s1_pix;
    res_bottom.row  = s1_row;
    res_bottom.col  = 12'(s1_col);
    res_bottom.last = 1'b0;
  end

  // Pack the results from slot 0 and flag the final one
  always_comb begin
    slots = '0;
    count = '0;
    if (emit_diag) begin
      slots[count] = res_diag;
      count = count + 2'd1;
    end
    if (emit_right) begin
      slots[count] = res_right;
      count = count + 2'd1;
    end
    if (emit_bottom) begin
      slots[count] = res_bottom;
      count = count + 2'd1;
    end
    if (count != 2'd0) begin
      slots[count - 2'd1].last = 1'b1;
    end
  end

  assign s1_go = s1_valid && ((count == 2'd0) || emit_ready);
  assign busy  = s1_valid && !s1_go;

  assign group.push  = s1_go && (count != 2'd0);
  assign group.count = count;
  assign group.slot  = slots;

  // Write back: middle row moves up, new pixel becomes the middle row
  assign ram_we    = s1_go;
  assign ram_waddr = s1_col;
  assign ram_wdata = {cur.mid, s1_pix};

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the pixel and note a same-cycle write to the address being read
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix      <= pix_in;
      s1_col      <= col;
      s1_row      <= row;
      s1_edge     <= edges;
      s1_fwd      <= s1_go && (col == s1_col);
      s1_fwd_data <= {cur.mid, s1_pix};
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (rst) begin
      win0 <= '0;
      win1 <= '0;
    end else if (s1_go) begin
      win0 <= win1;
      win1 <= cur;
    end
  end

endmodule

// File: rtl/core/gb3_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gb3_emit
// Output register for up to three results per pixel, one per unstalled clock.
// ----------------------------------------------------------------------------
module gb3_emit (
  input  logic                clk,
  input  logic                rst,
  input  gb3_pkg::res_group_t group,
  input  logic                out_accept,
  output logic                ready,
  output logic                out_valid,
  output gb3_pkg::result_t    out_res
);

  logic [1:0]                 count;
  logic [1:0]                 count_next;
  gb3_pkg::result_t [2:0]     slots;

  assign ready     = (count == 2'd0) || ((count == 2'd1) && out_accept);
  assign out_valid = (count != 2'd0);
  assign out_res   = slots[0];

  assign count_next = group.push ? group.count : (count - {1'b0, out_accept});

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Load a new group or advance to the next result
  always_ff @(posedge clk) begin
    if (group.push) begin
      slots <= group.slot;
    end else if (out_accept) begin
      slots[0] <= slots[1];
      slots[1] <= slots[2];
    end
  end

endmodule
